// File: rtl/hsvrgb_pkg.sv
// shared types, constants and widths for the hsv to rgb converter
package hsvrgb_pkg;

   localparam int unsigned HueW = 9;
   localparam int unsigned PctW = 7;
   localparam int unsigned ChanW = 8;

   localparam int unsigned HueWrap = 360;
   localparam int unsigned SextDeg = 60;
   localparam int unsigned PctMod = 101;
   localparam int unsigned PctFull = 100;
   localparam int unsigned Denom = 600000;
   localparam int unsigned VScale = Denom / PctFull;

   // q in 0..Denom over Denom; (510q + 600000) / 1200000 reduced by 30
   localparam int unsigned QW = 20;
   localparam int unsigned ScaleNum = 17;
   localparam int unsigned ScaleBias = 20000;
   localparam int unsigned ScaleShift = 6;
   localparam int unsigned NumW = 24;
   localparam int unsigned AW = 18;

   // divide by 625 with a reciprocal, then one correction step
   localparam int unsigned RecipDiv = 625;
   localparam int unsigned RecipShift = 25;
   localparam int unsigned RecipMul = (1 << RecipShift) / RecipDiv;
   localparam int unsigned ProdW = 34;

   localparam int unsigned FracW = 6;
   localparam int unsigned SpanW = 2 * PctW;

   typedef enum logic [2:0] {
      SEXT_RED_YEL = 3'd0,
      SEXT_YEL_GRN = 3'd1,
      SEXT_GRN_CYN = 3'd2,
      SEXT_CYN_BLU = 3'd3,
      SEXT_BLU_MAG = 3'd4,
      SEXT_MAG_RED = 3'd5
   } sext_type;

   typedef struct packed {
      logic [HueW-1:0] hue;
      logic [PctW-1:0] saturation;
      logic [PctW-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } rsp_type;

endpackage

// File: rtl/hsvrgb_scale.sv
// scales a fraction over the common denominator to 0..255, three register stages
module hsvrgb_scale (
   input  logic                       clock,
   input  logic [hsvrgb_pkg::QW-1:0]  q,
   output logic [hsvrgb_pkg::ChanW-1:0] y
);
   import hsvrgb_pkg::*;

   logic [NumW-1:0]  num;
   logic [AW-1:0]    a_in, a_ff, a_e_ff;
   logic [ProdW-1:0] prod;
   logic [ChanW-1:0] est_in, est_ff;
   logic [AW-1:0]    rem;
   logic [ChanW-1:0] y_in, y_ff;

   assign num  = NumW'(q) * NumW'(ScaleNum) + NumW'(ScaleBias);
   assign a_in = AW'(num >> ScaleShift);

   // estimate is the quotient or one below it
   assign prod   = ProdW'(a_ff) * ProdW'(RecipMul);
   assign est_in = ChanW'(prod >> RecipShift);

   assign rem  = a_e_ff - AW'(est_ff) * AW'(RecipDiv);
   assign y_in = est_ff + ChanW'(rem >= AW'(RecipDiv));

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      a_e_ff <= a_ff;
      est_ff <= est_in;
      y_ff   <= y_in;
   end

   assign y = y_ff;

endmodule

// File: rtl/hsv_to_rgb_converter.sv
// hsv to rgb converter: eight-stage pipeline, one beat per clock
// throughput: one beat every cycle; busy stays low, the pipeline never stalls
// each scaled channel passes through a reciprocal multiply and a correction stage
// reset (synchronous, active high) clears all valid bits; results in flight are dropped
module hsv_to_rgb_converter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  hsvrgb_pkg::req_type   req_data,
   output logic                  rsp_strobe,
   output hsvrgb_pkg::rsp_type   rsp_data
);
   import hsvrgb_pkg::*;

   localparam int unsigned ScaleLat = 3;

   // stage 1: wrap inputs, find sextant and fraction
   logic [HueW-1:0]  hm;
   logic [PctW-1:0]  sm, vm;
   sext_type         sext1_in;
   logic [HueW-1:0]  base1;
   logic [FracW-1:0] frac1_in;

   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   sext_type         sext1_ff, sext2_ff, sext3_ff, sext4_ff;
   logic [FracW-1:0] frac1_ff, frac2_ff;
   logic [PctW-1:0]  sm1_ff, vm1_ff;

   assign hm = (req_data.hue >= HueW'(HueWrap)) ? req_data.hue - HueW'(HueWrap) : req_data.hue;
   assign sm = (req_data.saturation >= PctW'(PctMod)) ?
               req_data.saturation - PctW'(PctMod) : req_data.saturation;
   assign vm = (req_data.brightness >= PctW'(PctMod)) ?
               req_data.brightness - PctW'(PctMod) : req_data.brightness;

   always_comb begin
      if (hm >= HueW'(5 * SextDeg)) begin
         sext1_in = SEXT_MAG_RED;
         base1    = HueW'(5 * SextDeg);
      end else if (hm >= HueW'(4 * SextDeg)) begin
         sext1_in = SEXT_BLU_MAG;
         base1    = HueW'(4 * SextDeg);
      end else if (hm >= HueW'(3 * SextDeg)) begin
         sext1_in = SEXT_CYN_BLU;
         base1    = HueW'(3 * SextDeg);
      end else if (hm >= HueW'(2 * SextDeg)) begin
         sext1_in = SEXT_GRN_CYN;
         base1    = HueW'(2 * SextDeg);
      end else if (hm >= HueW'(SextDeg)) begin
         sext1_in = SEXT_YEL_GRN;
         base1    = HueW'(SextDeg);
      end else begin
         sext1_in = SEXT_RED_YEL;
         base1    = '0;
      end
   end

   assign frac1_in = FracW'(hm - base1);

   // stage 2: v*s and v over the common denominator
   logic [SpanW-1:0] vs2_in, vs2_ff;
   logic [QW-1:0]    vq2_in, vq2_ff;

   assign vs2_in = SpanW'(vm1_ff) * SpanW'(sm1_ff);
   assign vq2_in = QW'(vm1_ff) * QW'(VScale);

   // stage 3: minimum and the ramp, v*s times the fraction within the sextant
   logic [QW-1:0] span3_in, mq3_in, span3_ff, mq3_ff, vq3_ff;

   assign span3_in = QW'(vs2_ff) * QW'(frac2_ff);
   assign mq3_in   = vq2_ff - QW'(vs2_ff) * QW'(SextDeg);

   // stage 4: interpolated component, falling in odd sextants
   logic [QW-1:0] xq4_in, xq4_ff, vq4_ff, mq4_ff;

   assign xq4_in = (sext3_ff inside {SEXT_YEL_GRN, SEXT_CYN_BLU, SEXT_MAG_RED}) ?
                   vq3_ff - span3_ff : mq3_ff + span3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sext1_ff <= sext1_in;
      frac1_ff <= frac1_in;
      sm1_ff   <= sm;
      vm1_ff   <= vm;
      sext2_ff <= sext1_ff;
      frac2_ff <= frac1_ff;
      vs2_ff   <= vs2_in;
      vq2_ff   <= vq2_in;
      sext3_ff <= sext2_ff;
      span3_ff <= span3_in;
      mq3_ff   <= mq3_in;
      vq3_ff   <= vq2_ff;
      sext4_ff <= sext3_ff;
      xq4_ff   <= xq4_in;
      vq4_ff   <= vq3_ff;
      mq4_ff   <= mq3_ff;
   end

   // stages 5 to 7: scale each component to 255
   logic [ChanW-1:0] v8, m8, x8;

   hsvrgb_scale u_scale_v (.clock(clock), .q(vq4_ff), .y(v8));
   hsvrgb_scale u_scale_m (.clock(clock), .q(mq4_ff), .y(m8));
   hsvrgb_scale u_scale_x (.clock(clock), .q(xq4_ff), .y(x8));

   logic     sv_ff [ScaleLat];
   sext_type ss_ff [ScaleLat];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ScaleLat; i++) begin
            sv_ff[i] <= 1'b0;
         end
      end else begin
         sv_ff[0] <= v4_ff;
         for (int i = 1; i < ScaleLat; i++) begin
            sv_ff[i] <= sv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ss_ff[0] <= sext4_ff;
      for (int i = 1; i < ScaleLat; i++) begin
         ss_ff[i] <= ss_ff[i-1];
      end
   end

   // stage 8: route by sextant
   rsp_type rsp_in, rsp_ff;
   logic    strobe_ff;

   always_comb begin
      case (ss_ff[ScaleLat-1])
         SEXT_RED_YEL: rsp_in = '{red: v8, green: x8, blue: m8};
         SEXT_YEL_GRN: rsp_in = '{red: x8, green: v8, blue: m8};
         SEXT_GRN_CYN: rsp_in = '{red: m8, green: v8, blue: x8};
         SEXT_CYN_BLU: rsp_in = '{red: m8, green: x8, blue: v8};
         SEXT_BLU_MAG: rsp_in = '{red: x8, green: m8, blue: v8};
         default:      rsp_in = '{red: v8, green: m8, blue: x8};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= sv_ff[ScaleLat-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/hsvrgb_checker.sv
// port-level checks for the hsv to rgb converter, bound to the top level
module hsvrgb_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input hsvrgb_pkg::req_type req_data,
   input logic                rsp_strobe,
   input hsvrgb_pkg::rsp_type rsp_data
);
   import hsvrgb_pkg::*;

   localparam int unsigned Lat = 8;

   // pipeline never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every beat taken comes out after the fixed latency
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 rsp_strobe)
      else $error("accepted beat not delivered");

   // no result without a beat taken earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, Lat))
      else $error("result without a request");

   // zero saturation gives a gray result
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.saturation, Lat) == '0) |->
         (rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue))
      else $error("zero saturation not gray");

   // zero brightness gives black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.brightness, Lat) == '0) |->
         (rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0))
      else $error("zero brightness not black");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_data(req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data(rsp_data)
);

// File: tb/tb_hsv_to_rgb_converter.sv
// self-checking testbench for the hsv to rgb converter: directed corners, then random traffic
module tb_hsv_to_rgb_converter;
   import hsvrgb_pkg::*;

   localparam int unsigned HUE_CIRCLE   = 360;
   localparam int unsigned HUE_SECTOR   = 60;
   localparam int unsigned PCT_WRAP     = 101;
   localparam int unsigned PCT_MAX      = 100;
   localparam longint unsigned FULL_Q   = 600000;
   localparam longint unsigned CHAN_MAX = 255;
   localparam int unsigned PIPE_DEPTH   = 8;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type     rgb_expected[$];
   int          error_count;
   int          idle_pct;
   int unsigned cycle_count;

   hsv_to_rgb_converter uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // q is a fraction over FULL_Q, rounded to nearest with ties up
   function automatic logic [7:0] scale_to_chan(longint unsigned q);
      longint unsigned scaled;
      scaled = (2 * CHAN_MAX * q + FULL_Q) / (2 * FULL_Q);
      return scaled[7:0];
   endfunction

   function automatic rsp_type rgb_from_hsv(req_type color);
      longint unsigned hue_deg, sat_pct, val_pct, sector, offset;
      longint unsigned max_q, min_q, ramp, mid_q;
      logic [7:0]      max_c, min_c, mid_c;
      rsp_type         rgb;
      hue_deg = color.hue % HUE_CIRCLE;
      sat_pct = color.saturation % PCT_WRAP;
      val_pct = color.brightness % PCT_WRAP;
      sector  = hue_deg / HUE_SECTOR;
      offset  = hue_deg % HUE_SECTOR;
      max_q   = val_pct * (FULL_Q / PCT_MAX);
      min_q   = val_pct * (PCT_MAX - sat_pct) * HUE_SECTOR;
      ramp    = val_pct * sat_pct * offset;
      // rising ramp in even sectors, falling in odd ones
      mid_q   = sector[0] ? (max_q - ramp) : (min_q + ramp);
      max_c   = scale_to_chan(max_q);
      min_c   = scale_to_chan(min_q);
      mid_c   = scale_to_chan(mid_q);
      case (sext_type'(sector[2:0]))
         SEXT_RED_YEL: rgb = '{red: max_c, green: mid_c, blue: min_c};
         SEXT_YEL_GRN: rgb = '{red: mid_c, green: max_c, blue: min_c};
         SEXT_GRN_CYN: rgb = '{red: min_c, green: max_c, blue: mid_c};
         SEXT_CYN_BLU: rgb = '{red: min_c, green: mid_c, blue: max_c};
         SEXT_BLU_MAG: rgb = '{red: mid_c, green: min_c, blue: max_c};
         default:      rgb = '{red: max_c, green: min_c, blue: mid_c};
      endcase
      return rgb;
   endfunction

   // check the oldest expectation on each strobe, then record the beat taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (rgb_expected.size() == 0) begin
               $error("unexpected result: red %0d green %0d blue %0d",
                      rsp_data.red, rsp_data.green, rsp_data.blue);
               error_count++;
            end else begin
               want = rgb_expected.pop_front();
               if (rsp_data.red !== want.red) begin
                  $error("red: expected %0d, actual %0d", want.red, rsp_data.red);
                  error_count++;
               end
               if (rsp_data.green !== want.green) begin
                  $error("green: expected %0d, actual %0d", want.green, rsp_data.green);
                  error_count++;
               end
               if (rsp_data.blue !== want.blue) begin
                  $error("blue: expected %0d, actual %0d", want.blue, rsp_data.blue);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            rgb_expected.push_back(rgb_from_hsv(req_data));
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_color(req_type color);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= color;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_hsv(int unsigned hue, int unsigned sat, int unsigned val);
      req_type color;
      color.hue        = hue[HueW-1:0];
      color.saturation = sat[PctW-1:0];
      color.brightness = val[PctW-1:0];
      send_color(color);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (rgb_expected.size() != 0) @(posedge clock);
   endtask

   function automatic req_type random_color();
      req_type color;
      if ($urandom_range(7) == 0) begin
         // raw field bits, out-of-range codes included
         color = req_type'($urandom);
      end else begin
         color.hue        = HueW'($urandom_range(HUE_CIRCLE - 1));
         color.saturation = PctW'($urandom_range(PCT_MAX));
         color.brightness = PctW'($urandom_range(PCT_MAX));
         if ($urandom_range(9) == 0) color.saturation = PctW'(PCT_MAX);
         if ($urandom_range(9) == 0) color.brightness = PctW'(PCT_MAX);
         if ($urandom_range(19) == 0) color.saturation = '0;
      end
      return color;
   endfunction

   task automatic test_sector_edges();
      int unsigned sector;
      for (sector = 0; sector < 6; sector++) begin
         send_hsv(sector * HUE_SECTOR, PCT_MAX, PCT_MAX);
         send_hsv(sector * HUE_SECTOR + HUE_SECTOR - 1, PCT_MAX, PCT_MAX);
      end
   endtask

   task automatic test_grey_and_black();
      send_hsv(200, 0, PCT_MAX);
      send_hsv(30, PCT_MAX, 0);
      send_hsv(0, 0, 0);
      send_hsv(90, 50, 50);
      send_hsv(150, 1, 1);
   endtask

   task automatic test_out_of_range_codes();
      send_hsv(360, PCT_MAX, PCT_MAX);
      send_hsv(511, PCT_MAX, PCT_MAX);
      send_hsv(45, 101, PCT_MAX);
      send_hsv(45, 127, 80);
      send_hsv(270, 60, 127);
      send_hsv(511, 127, 127);
   endtask

   task automatic test_random_traffic(int unsigned beats, int pct);
      idle_pct = pct;
      repeat (beats) send_color(random_color());
   endtask

   initial begin
      int unsigned wait_cycles;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      error_count = 0;
      idle_pct    = 38;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_sector_edges();
      test_grey_and_black();
      test_out_of_range_codes();
      pause_until_drained();

      test_random_traffic(550, 38);
      pause_until_drained();
      test_random_traffic(550, 72);
      test_random_traffic(500, 0);

      @(negedge clock);
      start <= 1'b0;
      wait_cycles = 0;
      while (rgb_expected.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (rgb_expected.size() != 0) begin
         $error("%0d expected results never arrived", rgb_expected.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
